FILE: hw/rtl/baro_sensor_compensation_defines.svh
// Assertion macros used by the checker file of the block.
`ifndef BARO_SENSOR_COMPENSATION_DEFINES_SVH
`define BARO_SENSOR_COMPENSATION_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define BSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("baro compensation check failed");

// The antecedent implies the consequent in the next cycle.
`define BSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("baro compensation check failed");

`endif

FILE: hw/rtl/bsc_pkg.sv
`timescale 1ns / 1ps

package bsc_pkg;

    localparam int W_RAW  = 24;
    localparam int W_COEF = 16;
    localparam int W_OUT  = 32;
    localparam int W_IDX  = 3;

    localparam int C_TEMP_REF = 2000;
    localparam int C_TEMP_LOW = -1500;

    typedef enum logic [W_IDX-1:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [W_COEF-1:0] c1;
        logic [W_COEF-1:0] c2;
        logic [W_COEF-1:0] c3;
        logic [W_COEF-1:0] c4;
        logic [W_COEF-1:0] c5;
        logic [W_COEF-1:0] c6;
    } t_cfg;

    // First-order terms and squares handed from the front half to the back half.
    typedef struct packed {
        logic [W_RAW-1:0]   d1;
        logic signed [18:0] tm;
        logic [17:0]        t2;
        logic               low;
        logic               vlow;
        logic signed [37:0] off1;
        logic signed [36:0] sens1;
        logic [35:0]        tm2;
        logic [35:0]        tp2;
    } t_front;

endpackage

FILE: hw/rtl/baro_sensor_compensation.sv
// Barometric sensor compensation with second-order low-temperature correction.
// Items enter on the slave stream: one raw pressure and one raw temperature
// reading per item. Each item gives one result item on the master stream with
// the compensated pressure in pascals and the temperature in hundredths of a
// degree, both as 32-bit two's complement values.
// The six calibration words are written through the configuration channel,
// which is always ready; they should be written while no item is in flight.
// Throughput is one item per cycle while the receiver does not stall; each of
// the eight register stages then takes a new item every cycle, and the widest
// multiplier is the 25 by 25 bit square.
// When the receiver stalls, the whole pipeline holds and the input is not
// ready; nothing is lost or repeated. The last stage is the output register.
// Reset clears all stage valid bits and sets every calibration word to zero.
`timescale 1ns / 1ps

module baro_sensor_compensation (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [47:0]                 i_s_tdata,   // raw_pressure, raw_temperature
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [63:0]                 o_m_tdata,   // pressure_pa, temperature_centi
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bsc_pkg::W_IDX-1:0]   i_cfg_addr,
    input  logic [bsc_pkg::W_COEF-1:0]  i_cfg_data
);

    bsc_pkg::t_cfg             w_cfg;
    bsc_pkg::t_front           w_front;
    logic                      w_front_vld;
    logic                      w_en;
    logic [bsc_pkg::W_OUT-1:0] w_press;
    logic [bsc_pkg::W_OUT-1:0] w_temp;

    assign w_en        = !o_m_tvalid || i_m_tready;
    assign o_s_tready  = w_en;
    assign o_cfg_ready = 1'b1;

    bsc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_addr  (i_cfg_addr),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    bsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_d1    (i_s_tdata[23:0]),
        .i_d2    (i_s_tdata[47:24]),
        .i_cfg   (w_cfg),
        .o_valid (w_front_vld),
        .o_data  (w_front)
    );

    bsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_front_vld),
        .i_data  (w_front),
        .o_valid (o_m_tvalid),
        .o_press (w_press),
        .o_temp  (w_temp)
    );

    assign o_m_tdata = {w_temp, w_press};

endmodule

FILE: hw/rtl/bsc_cfg_regs.sv
`timescale 1ns / 1ps

module bsc_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr,
    input  logic [bsc_pkg::W_IDX-1:0]  i_addr,
    input  logic [bsc_pkg::W_COEF-1:0] i_data,
    output bsc_pkg::t_cfg              o_cfg
);

    bsc_pkg::t_cfg r_cfg;
    bsc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (bsc_pkg::t_reg_idx'(i_addr))
                bsc_pkg::REG_C1: n_cfg.c1 = i_data;
                bsc_pkg::REG_C2: n_cfg.c2 = i_data;
                bsc_pkg::REG_C3: n_cfg.c3 = i_data;
                bsc_pkg::REG_C4: n_cfg.c4 = i_data;
                bsc_pkg::REG_C5: n_cfg.c5 = i_data;
                bsc_pkg::REG_C6: n_cfg.c6 = i_data;
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/bsc_front.sv
`timescale 1ns / 1ps

module bsc_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [bsc_pkg::W_RAW-1:0] i_d1,
    input  logic [bsc_pkg::W_RAW-1:0] i_d2,
    input  bsc_pkg::t_cfg             i_cfg,
    output logic                      o_valid,
    output bsc_pkg::t_front           o_data
);

    logic [3:0] r_vld;

    logic [bsc_pkg::W_RAW-1:0] r_s1_d1;
    logic signed [24:0]        r_s1_dt;
    logic signed [24:0]        n_s1_dt;

    logic [bsc_pkg::W_RAW-1:0] r_s2_d1;
    logic signed [41:0]        r_s2_p_tc;
    logic signed [41:0]        r_s2_p_off;
    logic signed [41:0]        r_s2_p_sens;
    logic signed [49:0]        r_s2_dsq;
    logic signed [41:0]        n_s2_p_tc;
    logic signed [41:0]        n_s2_p_off;
    logic signed [41:0]        n_s2_p_sens;
    logic signed [49:0]        n_s2_dsq;

    logic [bsc_pkg::W_RAW-1:0] r_s3_d1;
    logic signed [18:0]        r_s3_tm;
    logic signed [19:0]        r_s3_tp;
    logic [17:0]               r_s3_t2;
    logic                      r_s3_low;
    logic                      r_s3_vlow;
    logic signed [37:0]        r_s3_off1;
    logic signed [36:0]        r_s3_sens1;
    logic signed [18:0]        n_s3_tm;
    logic signed [19:0]        n_s3_tp;
    logic signed [37:0]        n_s3_off1;
    logic signed [36:0]        n_s3_sens1;

    bsc_pkg::t_front    r_s4;
    logic signed [37:0] n_s4_tm2;
    logic signed [39:0] n_s4_tp2;

    always_comb begin
        n_s1_dt = $signed({1'b0, i_d2}) - $signed({1'b0, i_cfg.c5, 8'h00});

        n_s2_p_tc   = r_s1_dt * $signed({1'b0, i_cfg.c6});
        n_s2_p_off  = r_s1_dt * $signed({1'b0, i_cfg.c4});
        n_s2_p_sens = r_s1_dt * $signed({1'b0, i_cfg.c3});
        n_s2_dsq    = r_s1_dt * r_s1_dt;

        n_s3_tm    = $signed(r_s2_p_tc[41:23]);
        n_s3_tp    = 20'(n_s3_tm) + 20'(bsc_pkg::C_TEMP_REF - bsc_pkg::C_TEMP_LOW);
        n_s3_off1  = $signed({5'b0, i_cfg.c2, 17'b0}) + 38'($signed(r_s2_p_off[41:6]));
        n_s3_sens1 = $signed({5'b0, i_cfg.c1, 16'b0}) + 37'($signed(r_s2_p_sens[41:7]));

        n_s4_tm2 = r_s3_tm * r_s3_tm;
        n_s4_tp2 = r_s3_tp * r_s3_tp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_d1 <= i_d1;
            r_s1_dt <= n_s1_dt;

            r_s2_d1     <= r_s1_d1;
            r_s2_p_tc   <= n_s2_p_tc;
            r_s2_p_off  <= n_s2_p_off;
            r_s2_p_sens <= n_s2_p_sens;
            r_s2_dsq    <= n_s2_dsq;

            r_s3_d1    <= r_s2_d1;
            r_s3_tm    <= n_s3_tm;
            r_s3_tp    <= n_s3_tp;
            r_s3_t2    <= r_s2_dsq[48:31];
            r_s3_low   <= n_s3_tm[18];
            r_s3_vlow  <= n_s3_tm < 19'(bsc_pkg::C_TEMP_LOW - bsc_pkg::C_TEMP_REF);
            r_s3_off1  <= n_s3_off1;
            r_s3_sens1 <= n_s3_sens1;

            r_s4.d1    <= r_s3_d1;
            r_s4.tm    <= r_s3_tm;
            r_s4.t2    <= r_s3_t2;
            r_s4.low   <= r_s3_low;
            r_s4.vlow  <= r_s3_vlow;
            r_s4.off1  <= r_s3_off1;
            r_s4.sens1 <= r_s3_sens1;
            r_s4.tm2   <= n_s4_tm2[35:0];
            r_s4.tp2   <= n_s4_tp2[35:0];
        end
    end

    assign o_valid = r_vld[3];
    assign o_data  = r_s4;

endmodule

FILE: hw/rtl/bsc_back.sv
`timescale 1ns / 1ps

module bsc_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  bsc_pkg::t_front           i_data,
    output logic                      o_valid,
    output logic [bsc_pkg::W_OUT-1:0] o_press,
    output logic [bsc_pkg::W_OUT-1:0] o_temp
);

    logic [3:0] r_vld;

    bsc_pkg::t_front r_s5;
    logic [41:0]     r_s5_off2;
    logic [40:0]     r_s5_sens2;
    logic [41:0]     n_s5_off2;
    logic [40:0]     n_s5_sens2;

    logic [bsc_pkg::W_RAW-1:0] r_s6_d1;
    logic signed [42:0]        r_s6_off;
    logic signed [42:0]        r_s6_sens;
    logic signed [20:0]        r_s6_temp;
    logic signed [42:0]        n_s6_off;
    logic signed [42:0]        n_s6_sens;
    logic signed [20:0]        n_s6_temp;

    logic signed [42:0] r_s7_off;
    logic signed [20:0] r_s7_temp;
    logic [43:0]        r_s7_pl;
    logic signed [47:0] r_s7_ph;
    logic [43:0]        n_s7_pl;
    logic signed [47:0] n_s7_ph;

    logic [bsc_pkg::W_OUT-1:0] r_press;
    logic [bsc_pkg::W_OUT-1:0] r_temp;
    logic signed [67:0]        n_s8_prod;
    logic signed [47:0]        n_s8_diff;

    always_comb begin
        n_s5_off2  = ((42'(i_data.tm2) * 42'd61) >> 4)
                   + (i_data.vlow ? 42'(i_data.tp2) * 42'd15 : 42'd0);
        n_s5_sens2 = (41'(i_data.tm2) << 1)
                   + (i_data.vlow ? 41'(i_data.tp2) << 3 : 41'd0);

        n_s6_off  = 43'(r_s5.off1) - (r_s5.low ? $signed({1'b0, r_s5_off2}) : 43'sd0);
        n_s6_sens = 43'(r_s5.sens1) - (r_s5.low ? $signed({2'b0, r_s5_sens2}) : 43'sd0);
        n_s6_temp = 21'(r_s5.tm) + 21'(bsc_pkg::C_TEMP_REF)
                  - (r_s5.low ? $signed({3'b0, r_s5.t2}) : 21'sd0);

        // The pressure product is split into a low unsigned and a high signed part.
        n_s7_pl = r_s6_d1 * r_s6_sens[19:0];
        n_s7_ph = $signed({1'b0, r_s6_d1}) * $signed(r_s6_sens[42:20]);

        n_s8_prod = (68'(r_s7_ph) <<< 20) + $signed({24'b0, r_s7_pl});
        n_s8_diff = 48'(n_s8_prod >>> 21) - 48'(r_s7_off);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s5       <= i_data;
            r_s5_off2  <= n_s5_off2;
            r_s5_sens2 <= n_s5_sens2;

            r_s6_d1   <= r_s5.d1;
            r_s6_off  <= n_s6_off;
            r_s6_sens <= n_s6_sens;
            r_s6_temp <= n_s6_temp;

            r_s7_off  <= r_s6_off;
            r_s7_temp <= r_s6_temp;
            r_s7_pl   <= n_s7_pl;
            r_s7_ph   <= n_s7_ph;

            r_press <= 32'(n_s8_diff >>> 15);
            r_temp  <= 32'(r_s7_temp);
        end
    end

    assign o_valid = r_vld[3];
    assign o_press = r_press;
    assign o_temp  = r_temp;

endmodule

FILE: hw/rtl/bsc_checker.sv
`timescale 1ns / 1ps
`include "baro_sensor_compensation_defines.svh"

module bsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata
);

    // A stalled result stays valid and unchanged.
    `BSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // While the result is stalled the pipeline is frozen and takes no item.
    `BSC_ASSERT_IMPL(a_stall_blocks_in, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, !o_s_tready)

    // With an empty output stage the pipeline always moves.
    `BSC_ASSERT_IMPL(a_empty_accepts, i_clk, i_rst_n, !o_m_tvalid, o_s_tready)

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (.*);
